// ----- hdl/ctds_pkg.sv -----
// ----------------------------------------------------------------------------
// ctds_pkg
// Shared types, constants and helpers of the cycle timer, divider and
// scanline block.
// ----------------------------------------------------------------------------
`default_nettype none

package ctds_pkg;

   localparam int DEFICIT_W   = 64;
   localparam int TICK_W      = 18;
   localparam int TOTAL_W     = 10;
   localparam int TPERIOD_W   = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] LINE_LAST   = 8'h98;
   localparam logic [7:0] LINE_VBLANK = 8'h90;

   localparam int TCTRL_ENABLE = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMER_CONTROL = 2'd0,
      CSR_TIMER_RELOAD  = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      RATE_1024 = 2'd0,
      RATE_16   = 2'd1,
      RATE_64   = 2'd2,
      RATE_256  = 2'd3
   } rate_sel_type;

   function automatic logic [TPERIOD_W-1:0] rate_period(input rate_sel_type sel);
      logic [TPERIOD_W-1:0] p;
      unique case (sel)
         RATE_1024: p = 11'd1024;
         RATE_16:   p = 11'd16;
         RATE_64:   p = 11'd64;
         RATE_256:  p = 11'd256;
         default:   p = 11'd1024;
      endcase
      return p;
   endfunction

   function automatic logic [TOTAL_W-1:0] rate_mask(input rate_sel_type sel);
      logic [TPERIOD_W-1:0] p;
      p = rate_period(sel) - 11'd1;
      return p[TOTAL_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ctds_tick.sv -----
// ----------------------------------------------------------------------------
// ctds_tick
// Fixed-period tick source: keeps the cycles not yet turned into ticks and
// grants at most one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ctds_tick #(
   parameter int unsigned PERIOD = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] cycles,
   output logic            tick
);

   localparam int W  = ctds_pkg::TICK_W;
   localparam int DW = ctds_pkg::DEFICIT_W;
   localparam logic signed [W-1:0] PER = W'(PERIOD);

   logic [DW-1:0]       deficit_ff;
   logic [DW-1:0]       deficit_in;
   logic signed [W-1:0] diff;
   logic signed [W-1:0] delta;

   always_comb begin
      diff  = PER - signed'(W'(cycles));
      tick  = (diff <= 0) || (|deficit_ff[DW-1:W-1])
              || (deficit_ff[W-2:0] >= diff[W-2:0]);
      delta = signed'(W'(cycles)) - (tick ? PER : W'(0));
      deficit_in = deficit_ff;
      if (step) begin
         deficit_in = deficit_ff + {{(DW-W){delta[W-1]}}, delta};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deficit_ff <= '0;
      end else begin
         deficit_ff <= deficit_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ctds_timer.sv -----
// ----------------------------------------------------------------------------
// ctds_timer
// Reloadable 8-bit timer with selectable period, resync on a period change,
// enable gating and overflow interrupt.
// ----------------------------------------------------------------------------
`default_nettype none

module ctds_timer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] cycles,
   input  wire logic [2:0] control,
   input  wire logic [7:0] reload,
   output logic [7:0]      count,
   output logic            irq
);

   localparam int DW = ctds_pkg::DEFICIT_W;
   localparam int TW = ctds_pkg::TOTAL_W;
   localparam int PW = ctds_pkg::TPERIOD_W;

   ctds_pkg::rate_sel_type sel;
   ctds_pkg::rate_sel_type last_sel_ff, last_sel_in;
   logic [TW-1:0]          total_ff, total_in;
   logic [DW-1:0]          deficit_ff, deficit_in;
   logic [7:0]             count_ff, count_in;
   logic [PW-1:0]          period;
   logic signed [PW:0]     diff;
   logic signed [PW:0]     delta;
   logic                   resync;
   logic                   tick;
   logic                   enable;

   always_comb begin
      sel     = ctds_pkg::rate_sel_type'(control[1:0]);
      enable  = control[ctds_pkg::TCTRL_ENABLE];
      period  = ctds_pkg::rate_period(sel);
      resync  = (sel != last_sel_ff);
      total_in = total_ff;
      last_sel_in = last_sel_ff;
      deficit_in  = deficit_ff;
      count_in    = count_ff;
      irq         = 1'b0;

      diff  = signed'((PW+1)'(period)) - signed'((PW+1)'(cycles));
      tick  = !resync && ((diff <= 0) || (|deficit_ff[DW-1:PW])
              || (deficit_ff[PW-1:0] >= diff[PW-1:0]));
      delta = signed'((PW+1)'(cycles)) - (tick ? signed'((PW+1)'(period)) : (PW+1)'(0));

      if (step) begin
         total_in    = total_ff + TW'(cycles);
         last_sel_in = sel;
         if (resync) begin
            deficit_in = DW'(total_in & ctds_pkg::rate_mask(sel));
         end else begin
            deficit_in = deficit_ff + {{(DW-PW-1){delta[PW]}}, delta};
         end
         if (tick && enable) begin
            count_in = count_ff + 8'd1;
            if (count_ff == 8'hFF) begin
               count_in = reload;
               irq      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         deficit_ff  <= '0;
         count_ff    <= '0;
         last_sel_ff <= ctds_pkg::RATE_1024;
      end else begin
         total_ff    <= total_in;
         deficit_ff  <= deficit_in;
         count_ff    <= count_in;
         last_sel_ff <= last_sel_in;
      end
   end

   assign count = count_ff;

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(count_ff) && $stable(deficit_ff))
      else $error("timer state moved without a step");

   a_irq_reload: assert property (@(posedge clock) disable iff (reset)
      step && irq |=> count_ff == $past(reload))
      else $error("overflow did not load the reload value");

   a_resync_small: assert property (@(posedge clock) disable iff (reset)
      step && resync |=> deficit_ff < DW'(1024))
      else $error("resync left a residue beyond one period");

endmodule

`default_nettype wire

// ----- hdl/cycle_timer_divider_scanline.sv -----
// ----------------------------------------------------------------------------
// cycle_timer_divider_scanline
// Cycle-driven divider, scanline counter and reloadable interval timer.
//
// Requests carry the clock cycles elapsed since the previous request. Each
// request yields one response with the divider, scanline and timer values,
// the timer and vblank interrupt flags and the frame count after it.
// A request lands in an input register; when it advances, all counters and
// the response register update together. One request per cycle is
// sustained while rsp_ready stays high; each counter advances by at most
// one tick per request and catches up later. The csr_ channel writes
// timer_control (index 0) and timer_reload (index 1); it is always ready.
// It is to be written only while the block is idle; the block itself does
// not enforce this. Reset clears all counters, both registers and the
// period select (1024). When rsp_ready is low the response holds, the
// input register fills, and req_ready drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_timer_divider_scanline #(
   parameter int unsigned DIV_PERIOD  = 256,
   parameter int unsigned LINE_PERIOD = 456
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_cycles_elapsed,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [7:0]                              rsp_divider_value,
   output logic [7:0]                              rsp_line_value,
   output logic [7:0]                              rsp_timer_value,
   output logic                                    rsp_timer_interrupt,
   output logic                                    rsp_vblank_interrupt,
   output logic [31:0]                             rsp_frame_count,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ctds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ctds_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_cycles_ff, in_cycles_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  timer_control_ff, timer_control_in;
   logic [7:0]  timer_reload_ff, timer_reload_in;
   logic [7:0]  div_count_ff, div_count_in;
   logic [7:0]  line_count_ff, line_count_in;
   logic [31:0] frames_ff, frames_in;
   logic        tint_ff, tint_in;
   logic        vint_ff, vint_in;
   logic [7:0]  line_next;
   logic        advance;
   logic        div_tick;
   logic        line_tick;
   logic        timer_irq;
   logic [7:0]  timer_count;

   ctds_tick #(.PERIOD(DIV_PERIOD)) u_div_tick (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cycles (in_cycles_ff),
      .tick   (div_tick)
   );

   ctds_tick #(.PERIOD(LINE_PERIOD)) u_line_tick (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cycles (in_cycles_ff),
      .tick   (line_tick)
   );

   ctds_timer u_timer (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .cycles  (in_cycles_ff),
      .control (timer_control_ff),
      .reload  (timer_reload_ff),
      .count   (timer_count),
      .irq     (timer_irq)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_cycles_in = in_cycles_ff;
      if (req_valid && req_ready) begin
         in_valid_in  = 1'b1;
         in_cycles_in = req_cycles_elapsed;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      timer_control_in = timer_control_ff;
      timer_reload_in  = timer_reload_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ctds_pkg::CSR_TIMER_CONTROL: timer_control_in = csr_write_data[2:0];
            ctds_pkg::CSR_TIMER_RELOAD:  timer_reload_in  = csr_write_data;
            default: ;
         endcase
      end

      line_next     = (line_count_ff == ctds_pkg::LINE_LAST) ? 8'd0 : line_count_ff + 8'd1;
      div_count_in  = div_count_ff;
      line_count_in = line_count_ff;
      frames_in     = frames_ff;
      tint_in       = tint_ff;
      vint_in       = vint_ff;
      if (advance) begin
         tint_in = timer_irq;
         vint_in = 1'b0;
         if (div_tick) begin
            div_count_in = div_count_ff + 8'd1;
         end
         if (line_tick) begin
            line_count_in = line_next;
            if (line_next == ctds_pkg::LINE_VBLANK) begin
               vint_in   = 1'b1;
               frames_in = frames_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         timer_control_ff <= '0;
         timer_reload_ff  <= '0;
         div_count_ff     <= '0;
         line_count_ff    <= '0;
         frames_ff        <= '0;
         tint_ff          <= 1'b0;
         vint_ff          <= 1'b0;
      end else begin
         in_valid_ff      <= in_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         timer_control_ff <= timer_control_in;
         timer_reload_ff  <= timer_reload_in;
         div_count_ff     <= div_count_in;
         line_count_ff    <= line_count_in;
         frames_ff        <= frames_in;
         tint_ff          <= tint_in;
         vint_ff          <= vint_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cycles_ff <= in_cycles_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_divider_value    = div_count_ff;
   assign rsp_line_value       = line_count_ff;
   assign rsp_timer_value      = timer_count;
   assign rsp_timer_interrupt  = tint_ff;
   assign rsp_vblank_interrupt = vint_ff;
   assign rsp_frame_count      = frames_ff;

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_count_ff <= ctds_pkg::LINE_LAST)
      else $error("scanline counter out of range");

   a_vblank_line: assert property (@(posedge clock) disable iff (reset)
      vint_ff |-> line_count_ff == ctds_pkg::LINE_VBLANK)
      else $error("vblank flag without vblank line");

   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> frames_ff == $past(frames_ff) + 32'(vint_ff))
      else $error("frame count out of step with vblank");

   a_no_advance_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("counters advanced over a held response");

endmodule

`default_nettype wire

// ----- dv/cycle_timer_divider_scanline_tb.sv -----
// ----------------------------------------------------------------------------
// cycle_timer_divider_scanline_tb
// Self-checking bench for the cycle timer, divider and scanline block.
//
// Requests of elapsed cycles are sent under random flow control on both
// channels. A scoreboard keeps its own copy of the divider, scanline and
// timer state, predicts each response as a request is accepted, and checks
// every field of every response in order. The timer control and reload
// registers change between phases while the block is idle: every rate,
// enabled and disabled, extreme reload values, stray high bits and unused
// register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_timer_divider_scanline_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DIV_PERIOD    = 256;
   localparam int unsigned LINE_PERIOD   = 456;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          RANDOM_PHASES = 16;
   localparam int          PHASE_ITEMS   = 114;

   localparam logic [ctds_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [ctds_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam logic [7:0] DIRECTED_CYCLES [0:23] = '{
      8'd255, 8'd0, 8'd255, 8'd255, 8'd1, 8'd16, 8'd15, 8'd128,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd200,
      8'd64, 8'd63, 8'd255, 8'd0, 8'd255,
      8'd255, 8'd255, 8'd1, 8'd254, 8'd128
   };

   typedef struct packed {
      logic [7:0]  divider;
      logic [7:0]  line;
      logic [7:0]  timer;
      logic        timer_irq;
      logic        vblank_irq;
      logic [31:0] frames;
   } timer_snapshot_type;

   class timer_scoreboard;
      logic [2:0]             control;
      logic [7:0]             reload;
      logic [63:0]            total_cycles;
      logic [63:0]            divider_ticks;
      logic [63:0]            line_ticks;
      logic [63:0]            timer_ticks;
      ctds_pkg::rate_sel_type last_sel;
      logic [7:0]             divider;
      logic [7:0]             line;
      logic [7:0]             timer;
      logic [31:0]            frames;
      timer_snapshot_type     expected_snapshots [$];
      int                     errors;
      int                     requests;
      int                     overflows;
      int                     vblanks;
      int                     rate_changes;
      int                     writes;

      function new();
         control       = '0;
         reload        = '0;
         total_cycles  = '0;
         divider_ticks = '0;
         line_ticks    = '0;
         timer_ticks   = '0;
         last_sel      = ctds_pkg::RATE_1024;
         divider       = '0;
         line          = '0;
         timer         = '0;
         frames        = '0;
         errors        = 0;
         requests      = 0;
         overflows     = 0;
         vblanks       = 0;
         rate_changes  = 0;
         writes        = 0;
      endfunction

      function int pending();
         return expected_snapshots.size();
      endfunction

      task report_mismatch(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      function logic [63:0] timer_period(input ctds_pkg::rate_sel_type sel);
         case (sel)
            ctds_pkg::RATE_16:  return 64'd16;
            ctds_pkg::RATE_64:  return 64'd64;
            ctds_pkg::RATE_256: return 64'd256;
            default:            return 64'd1024;
         endcase
      endfunction

      function void write_register(input logic [ctds_pkg::CSR_INDEX_W-1:0] index,
                                   input logic [ctds_pkg::CSR_DATA_W-1:0] data);
         writes++;
         if (index == ctds_pkg::CSR_TIMER_CONTROL) begin
            control = data[2:0];
         end else if (index == ctds_pkg::CSR_TIMER_RELOAD) begin
            reload = data;
         end
      endfunction

      function timer_snapshot_type advance_counters(input logic [7:0] cycles);
         ctds_pkg::rate_sel_type sel;
         logic [63:0]            period;
         timer_snapshot_type     s;
         sel          = ctds_pkg::rate_sel_type'(control[1:0]);
         period       = timer_period(sel);
         s.timer_irq  = 1'b0;
         s.vblank_irq = 1'b0;
         total_cycles = total_cycles + 64'(cycles);
         if (sel != last_sel) begin
            timer_ticks = total_cycles / period;
            last_sel    = sel;
            rate_changes++;
         end
         if (total_cycles / 64'(DIV_PERIOD) > divider_ticks) begin
            divider_ticks = divider_ticks + 64'd1;
            divider       = divider + 8'd1;
         end
         if (total_cycles / 64'(LINE_PERIOD) > line_ticks) begin
            line_ticks = line_ticks + 64'd1;
            line       = (line == ctds_pkg::LINE_LAST) ? 8'd0 : line + 8'd1;
            if (line == ctds_pkg::LINE_VBLANK) begin
               s.vblank_irq = 1'b1;
               frames       = frames + 32'd1;
               vblanks++;
            end
         end
         if (total_cycles / period > timer_ticks) begin
            timer_ticks = timer_ticks + 64'd1;
            if (control[ctds_pkg::TCTRL_ENABLE]) begin
               timer = timer + 8'd1;
               if (timer == 8'd0) begin
                  timer       = reload;
                  s.timer_irq = 1'b1;
                  overflows++;
               end
            end
         end
         s.divider = divider;
         s.line    = line;
         s.timer   = timer;
         s.frames  = frames;
         return s;
      endfunction

      function void note_request(input logic [7:0] cycles);
         requests++;
         expected_snapshots.push_back(advance_counters(cycles));
      endfunction

      task check_response(input timer_snapshot_type got);
         timer_snapshot_type want;
         if (expected_snapshots.size() == 0) begin
            report_mismatch($sformatf("response with nothing outstanding, divider %0d",
                                      got.divider));
            return;
         end
         want = expected_snapshots.pop_front();
         if (got.divider !== want.divider)
            report_mismatch($sformatf("divider_value %0d, want %0d", got.divider, want.divider));
         if (got.line !== want.line)
            report_mismatch($sformatf("line_value %0d, want %0d", got.line, want.line));
         if (got.timer !== want.timer)
            report_mismatch($sformatf("timer_value %0d, want %0d", got.timer, want.timer));
         if (got.timer_irq !== want.timer_irq)
            report_mismatch($sformatf("timer_interrupt %b, want %b",
                                      got.timer_irq, want.timer_irq));
         if (got.vblank_irq !== want.vblank_irq)
            report_mismatch($sformatf("vblank_interrupt %b, want %b",
                                      got.vblank_irq, want.vblank_irq));
         if (got.frames !== want.frames)
            report_mismatch($sformatf("frame_count %0d, want %0d", got.frames, want.frames));
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [7:0]                       req_cycles_elapsed = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [7:0]                       rsp_divider_value;
   logic [7:0]                       rsp_line_value;
   logic [7:0]                       rsp_timer_value;
   logic                             rsp_timer_interrupt;
   logic                             rsp_vblank_interrupt;
   logic [31:0]                      rsp_frame_count;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [ctds_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ctds_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   logic                             steady = 1'b0;
   int                               cycle_count = 0;
   timer_scoreboard                  sb;

   cycle_timer_divider_scanline #(
      .DIV_PERIOD (DIV_PERIOD),
      .LINE_PERIOD(LINE_PERIOD)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cycles_elapsed  (req_cycles_elapsed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_divider_value   (rsp_divider_value),
      .rsp_line_value      (rsp_line_value),
      .rsp_timer_value     (rsp_timer_value),
      .rsp_timer_interrupt (rsp_timer_interrupt),
      .rsp_vblank_interrupt(rsp_vblank_interrupt),
      .rsp_frame_count     (rsp_frame_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 34);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_write_data);
         if (req_valid && req_ready)
            sb.note_request(req_cycles_elapsed);
         if (rsp_valid && rsp_ready)
            sb.check_response('{rsp_divider_value, rsp_line_value, rsp_timer_value,
                                rsp_timer_interrupt, rsp_vblank_interrupt,
                                rsp_frame_count});
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sb.pending());
      $display("FAILURE");
      $finish;
   end

   task automatic send_request(input logic [7:0] cycles);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 34)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cycles_elapsed <= cycles;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_register(input logic [ctds_pkg::CSR_INDEX_W-1:0] index,
                               input logic [ctds_pkg::CSR_DATA_W-1:0] data);
      csr_valid      <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [ctds_pkg::CSR_DATA_W-1:0] control,
                            input logic [ctds_pkg::CSR_DATA_W-1:0] reload);
      drain();
      set_register(ctds_pkg::CSR_TIMER_CONTROL, control);
      set_register(ctds_pkg::CSR_TIMER_RELOAD, reload);
      end_writes();
   endtask

   function automatic logic [7:0] pick_cycles();
      case ($urandom_range(9))
         0, 1, 2, 3: return 8'($urandom_range(255));
         4, 5, 6:    return 8'($urandom_range(255, 200));
         7:          return 8'd255;
         default:    return 8'($urandom_range(3));
      endcase
   endfunction

   initial begin
      logic [ctds_pkg::CSR_DATA_W-1:0] control;
      logic [ctds_pkg::CSR_DATA_W-1:0] reload;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rate 16, timer held, stray high bits and unused indexes
      set_register(ctds_pkg::CSR_TIMER_CONTROL, 8'hF9);
      set_register(CSR_SPARE_A, 8'hFF);
      set_register(CSR_SPARE_B, 8'h5A);
      set_register(ctds_pkg::CSR_TIMER_RELOAD, 8'hFF);
      end_writes();
      for (int i = 0; i < 24; i++) begin
         if (i == 8)  configure(8'h04, 8'h00);
         if (i == 14) configure(8'h06, 8'hFF);
         if (i == 19) configure(8'h07, 8'hFE);
         send_request(DIRECTED_CYCLES[i]);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       begin control = 8'h07; reload = 8'hFF; end
            1:       begin control = 8'h00; reload = 8'h00; end
            2:       begin control = 8'h05; reload = 8'hFF; end
            default: begin
               control = 8'($urandom_range(255));
               if ($urandom_range(3) != 0)
                  control[ctds_pkg::TCTRL_ENABLE] = 1'b1;
               reload = $urandom_range(1) ? 8'($urandom_range(255, 240))
                                          : 8'($urandom_range(255));
            end
         endcase
         configure(control, reload);
         steady = (p == 6 || p == 7);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 4 && i == 57) begin
               // hold requests until every response is back
               req_valid <= 1'b0;
               do @(posedge clock); while (sb.pending() != 0);
            end
            send_request(pick_cycles());
         end
      end
      steady = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived", sb.pending()));
      $display("Covered %0d requests over %0d register writes and %0d rate changes.",
               sb.requests, sb.writes, sb.rate_changes);
      $display("Saw %0d timer overflows, %0d vblank pulses, %0d mismatches.",
               sb.overflows, sb.vblanks, sb.errors);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/ctds_pkg.sv
hdl/ctds_tick.sv
hdl/ctds_timer.sv
hdl/cycle_timer_divider_scanline.sv
dv/cycle_timer_divider_scanline_tb.sv
